// File: rtl/core/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg: shared types and constants of the spring chain Verlet stepper
// Holds the transaction structs, the sequencer states and the reset values.
// ----------------------------------------------------------------------------
`default_nettype none
package scv_pkg;
	localparam int PARTICLES_DEF = 8;
	localparam logic [31:0] KAPPA_RST = 32'd4090497;
	localparam logic [31:0] DT_RST    = 32'd42950;
	localparam logic        REG_KAPPA = 1'b0;
	localparam logic        REG_DT    = 1'b1;
	localparam logic        OP_LOAD   = 1'b0;
	localparam logic        OP_STEP   = 1'b1;

	typedef struct packed {
		logic              op;
		logic [5:0]        particle_index;
		logic signed [31:0] position_in;
		logic signed [31:0] velocity_in;
		logic [31:0]       inverse_mass;
	} scv_in_t;

	typedef struct packed {
		logic [5:0]        particle_out;
		logic signed [31:0] position_out;
		logic signed [31:0] velocity_out;
		logic              last;
	} scv_out_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ACC0, ST_KICK1, ST_DRIFT, ST_ACC, ST_KICK2, ST_EMIT
	} scv_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/scv_mem.sv
// ----------------------------------------------------------------------------
// scv_mem: one word-wide synchronous RAM with valid bits
// Single write port, single registered read port; unwritten entries read 0.
// ----------------------------------------------------------------------------
`default_nettype none
module scv_mem #(
	parameter int DEPTH = scv_pkg::PARTICLES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);
	logic [31:0]      mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [31:0]      rd_q;
	logic             rv_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			rv_q <= vld_q[raddr];
		end
	end

	assign rdata = rv_q ? rd_q : 32'd0;
endmodule
`default_nettype wire

// File: rtl/core/scv_alu.sv
// ----------------------------------------------------------------------------
// scv_alu: two-stage multiply unit
// Stage 1 multiplies a signed 35-bit operand, split in a 17-bit and an 18-bit
// half, by an unsigned 32-bit one; stage 2 floor-shifts, adds the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module scv_alu (
	input  wire logic               clk,
	input  wire logic signed [34:0] a,
	input  wire logic        [31:0] b,
	input  wire logic        [5:0]  sh,
	input  wire logic signed [31:0] acc,
	output logic signed [31:0]      res
);
	logic signed [67:0] lo_s1, hi_s1;
	logic        [5:0]  sh_s1;
	logic signed [31:0] acc_s1;
	logic signed [67:0] prod;
	logic signed [67:0] shd;
	logic signed [66:0] tot;

	always_ff @(posedge clk) begin
		lo_s1  <= $signed({1'b0, a[16:0]}) * $signed({1'b0, b});
		hi_s1  <= $signed(a[34:17]) * $signed({1'b0, b});
		sh_s1  <= sh;
		acc_s1 <= acc;
	end

	always_comb begin
		prod = (hi_s1 <<< 17) + lo_s1;
		shd  = prod >>> sh_s1;
		tot  = 67'(shd) + 67'(acc_s1);
		if (shd > 68'sd4294967295) res = 32'sh7fffffff;
		else if (shd < -68'sd4294967296) res = 32'sh80000000;
		else res = scv_pkg::sat32(66'(tot));
	end
endmodule
`default_nettype wire

// File: rtl/core/spring_chain_verlet_step_top.sv
// ----------------------------------------------------------------------------
// spring_chain_verlet_step_top: fixed-point harmonic chain, velocity Verlet
// Positions, velocities, accelerations and inverse masses live in RAMs.
// ----------------------------------------------------------------------------
// A load transaction never raises busy, so loads can follow each other on
// every cycle. A step transaction runs a sequencer over the particle RAMs:
// an acceleration refresh pass (first step after reset or after any load),
// half kick, drift, acceleration pass, half kick, then the reports.
// Kick and drift passes go through RAM read, multiplier input, multiplier
// stage and write back for each particle; an acceleration pass reads the
// particle's and its neighbours' positions, then runs the multiplier twice,
// and the report pass reads each particle before it reports it. busy stays
// high while the step runs, through the last report; the next transaction can
// be accepted in the cycle after the last report. Reports come with valid high
// for exactly one cycle each, in particle order; the receiver cannot stall
// them, so sample every cycle valid is high. Write configuration only while
// busy is low.
// ----------------------------------------------------------------------------
`default_nettype none
module spring_chain_verlet_step_top #(
	parameter int PARTICLES = scv_pkg::PARTICLES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire scv_pkg::scv_in_t  in_data,
	output logic                 valid,
	output scv_pkg::scv_out_t      out_data,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [31:0]     cfg_data
);
	localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

	scv_pkg::scv_state_t st_q, st_d;
	logic [31:0] kappa_q, dt_q;
	logic        stale_q;
	logic [AW-1:0] idx_q;       // particle under work
	logic [3:0]    ph_q;        // phase inside one particle

	// RAM ports
	logic          u_we, v_we, a_we, m_we;
	logic [AW-1:0] u_wa, v_wa, a_wa, u_ra, v_ra, a_ra, m_ra;
	logic [31:0]   u_wd, v_wd, a_wd, u_rd, v_rd, a_rd, m_rd;
	logic signed [31:0] lap_t_q, force_q, stash_q;
	logic signed [34:0] lap_q;

	// Within a step, positions are written during the drift pass only; accelerations read
	// new positions, so the accel pass follows the drift pass completely.
	scv_mem #(.DEPTH(PARTICLES), .AW(AW)) u_mem (.clk, .arst_n, .we(u_we),
		.waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));
	scv_mem #(.DEPTH(PARTICLES), .AW(AW)) v_mem (.clk, .arst_n, .we(v_we),
		.waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
	scv_mem #(.DEPTH(PARTICLES), .AW(AW)) a_mem (.clk, .arst_n, .we(a_we),
		.waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	scv_mem #(.DEPTH(PARTICLES), .AW(AW)) m_mem (.clk, .arst_n, .we(m_we),
		.waddr(in_data.particle_index[AW-1:0]), .wdata(in_data.inverse_mass),
		.raddr(m_ra), .rdata(m_rd));

	logic signed [34:0] al_a;
	logic        [31:0] al_b;
	logic        [5:0]  al_sh;
	logic signed [31:0] al_acc, al_res;
	scv_alu u_alu (.clk, .a(al_a), .b(al_b), .sh(al_sh), .acc(al_acc), .res(al_res));

	logic accept, load_ok, last_p;
	assign accept  = start && !busy;
	assign load_ok = accept && in_data.op == scv_pkg::OP_LOAD &&
		{1'b0, in_data.particle_index} < 7'(PARTICLES);
	assign last_p  = idx_q == AW'(PARTICLES - 1);
	assign busy    = st_q != scv_pkg::ST_IDLE;

	// Per-particle phase counts: kick/drift use 4 phases, accel uses 8.
	// Kick/drift: 0 read, 1 alu in, 2 alu s1, 3 write.
	// Accel: 0 read u[i-1], 1 take left / read u[i], 2 take mid / read u[i+1],
	// 3 take right -> lap, 4 alu kappa, 5 take force, 6 alu invm, 7 write.
	logic pdone;
	always_comb begin
		case (st_q)
			scv_pkg::ST_ACC0, scv_pkg::ST_ACC: pdone = ph_q == 4'd7;
			scv_pkg::ST_EMIT:                  pdone = 1'b1;
			default:                           pdone = ph_q == 4'd3;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			scv_pkg::ST_IDLE:
				if (accept && in_data.op != scv_pkg::OP_LOAD)
					st_d = stale_q ? scv_pkg::ST_ACC0 : scv_pkg::ST_KICK1;
			scv_pkg::ST_ACC0:  if (pdone && last_p) st_d = scv_pkg::ST_KICK1;
			scv_pkg::ST_KICK1: if (pdone && last_p) st_d = scv_pkg::ST_DRIFT;
			scv_pkg::ST_DRIFT: if (pdone && last_p) st_d = scv_pkg::ST_ACC;
			scv_pkg::ST_ACC:   if (pdone && last_p) st_d = scv_pkg::ST_KICK2;
			scv_pkg::ST_KICK2: if (pdone && last_p) st_d = scv_pkg::ST_EMIT;
			scv_pkg::ST_EMIT:  if (last_p) st_d = scv_pkg::ST_IDLE;
			default:           st_d = scv_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath control
	logic is_acc, is_drift;
	always_comb begin
		is_acc   = st_q inside {scv_pkg::ST_ACC0, scv_pkg::ST_ACC};
		is_drift = st_q == scv_pkg::ST_DRIFT;
		u_ra = idx_q; v_ra = idx_q; a_ra = idx_q; m_ra = idx_q;
		if (is_acc && ph_q == 4'd0) u_ra = idx_q - AW'(1);
		if (is_acc && ph_q == 4'd2) u_ra = idx_q + AW'(1);
		u_we = load_ok; u_wa = in_data.particle_index[AW-1:0];
		u_wd = in_data.position_in;
		v_we = load_ok; v_wa = in_data.particle_index[AW-1:0];
		v_wd = in_data.velocity_in;
		m_we = load_ok;
		a_we = 1'b0; a_wa = idx_q; a_wd = al_res; v_wa = load_ok ? v_wa : idx_q;
		al_a = 35'(signed'(a_rd)); al_b = dt_q; al_sh = 6'd33;
		al_acc = signed'(v_rd);
		if (is_drift) begin
			al_a = 35'(signed'(v_rd)); al_sh = 6'd32; al_acc = signed'(u_rd);
		end
		if (is_acc) begin
			al_acc = '0;
			if (ph_q == 4'd6) begin
				al_a = 35'(force_q); al_b = m_rd; al_sh = 6'd16;
			end else begin
				al_a = lap_q; al_b = kappa_q; al_sh = 6'd16;
			end
		end
		if (ph_q == 4'd3 && !is_acc && busy && st_q != scv_pkg::ST_EMIT) begin
			if (is_drift) begin
				u_we = 1'b1; u_wa = idx_q; u_wd = al_res;
			end else begin
				v_we = 1'b1; v_wa = idx_q; v_wd = al_res;
			end
		end
		if (is_acc && ph_q == 4'd7) a_we = 1'b1;
		valid = st_q == scv_pkg::ST_EMIT && ph_q == 4'd1;
		out_data.particle_out = 6'(idx_q);
		out_data.position_out = signed'(u_rd);
		out_data.velocity_out = signed'(v_rd);
		out_data.last         = last_p;
	end

	// Emit needs a read first, so it walks two phases per particle; the emit
	// branch moves on only when phase 1 ends and does not consult pdone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= scv_pkg::ST_IDLE;
			kappa_q <= scv_pkg::KAPPA_RST;
			dt_q    <= scv_pkg::DT_RST;
			stale_q <= 1'b1;
			idx_q   <= '0;
			ph_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == scv_pkg::REG_KAPPA) kappa_q <= cfg_data;
				else if (cfg_index == scv_pkg::REG_DT) dt_q <= cfg_data;
			end
			if (accept && in_data.op == scv_pkg::OP_LOAD) stale_q <= 1'b1;
			if (st_q == scv_pkg::ST_ACC0) stale_q <= 1'b0;
			if (accept && in_data.op != scv_pkg::OP_LOAD) begin
				idx_q <= '0; ph_q <= '0;
			end else if (st_q == scv_pkg::ST_EMIT) begin
				if (ph_q == 4'd1) begin
					ph_q <= '0;
					st_q <= st_d;
					idx_q <= last_p ? '0 : idx_q + AW'(1);
				end else ph_q <= 4'd1;
			end else if (busy && pdone) begin
				ph_q  <= '0;
				idx_q <= last_p ? '0 : idx_q + AW'(1);
				st_q  <= st_d;
			end else if (busy) ph_q <= ph_q + 4'd1;
			if (!busy) st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (is_acc) begin
			if (ph_q == 4'd1) lap_t_q <= (idx_q == '0) ? 32'sd0 : signed'(u_rd);
			if (ph_q == 4'd2) stash_q <= signed'(u_rd);
			if (ph_q == 4'd3)
				lap_q <= 35'(lap_t_q) - (35'(stash_q) <<< 1) +
					(last_p ? 35'sd0 : 35'(signed'(u_rd)));
			if (ph_q == 4'd5) force_q <= al_res;
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for spring_chain_verlet_step_top
// Drives load and step transactions in bursts, runs a fixed-point velocity
// Verlet model of the chain alongside, and checks every particle report.
// ----------------------------------------------------------------------------
module tb;
	localparam int  N_PART  = 8;
	localparam longint Q_HI = 64'sd2147483647;
	localparam longint Q_LO = -64'sd2147483648;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	scv_pkg::scv_in_t  in_data = '0;
	logic        valid;
	scv_pkg::scv_out_t out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	spring_chain_verlet_step_top #(.PARTICLES(N_PART)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_data(in_data), .valid(valid), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Chain mirror: values held as 64-bit integers, always inside 32-bit range.
	longint   chain_pos [N_PART];
	longint   chain_vel [N_PART];
	longint   chain_acc [N_PART];
	longint   chain_invm [N_PART];
	bit       acc_stale;
	longint   kappa_r;
	longint   dt_r;
	scv_pkg::scv_out_t chain_report_q [$];
	int       mismatch_cnt;
	int       burst_left;

	function automatic longint clamp32(longint x);
		if (x > Q_HI) return Q_HI;
		if (x < Q_LO) return Q_LO;
		return x;
	endfunction

	// Spring force times inverse mass; >>> on a signed longint floors.
	task automatic refresh_accel();
		longint k_hi, k_lo, left, right, lap, spring_f;
		k_hi = kappa_r >> 16;
		k_lo = kappa_r & 64'hFFFF;
		for (int i = 0; i < N_PART; i++) begin
			left  = (i > 0) ? chain_pos[i-1] : 0;
			right = (i < N_PART-1) ? chain_pos[i+1] : 0;
			lap   = left - 2*chain_pos[i] + right;
			spring_f = clamp32(k_hi*lap + ((k_lo*lap) >>> 16));
			chain_acc[i] = clamp32((spring_f*chain_invm[i]) >>> 16);
		end
	endtask

	task automatic half_kick();
		for (int i = 0; i < N_PART; i++)
			chain_vel[i] = clamp32(chain_vel[i] + ((chain_acc[i]*dt_r) >>> 33));
	endtask

	// Apply one accepted transaction and queue the reports it should cause.
	// With zero_report set, the typed-in expectation (zero position and velocity) is queued.
	task automatic advance_chain(scv_pkg::scv_in_t it, bit zero_report);
		scv_pkg::scv_out_t r;
		if (it.op == scv_pkg::OP_LOAD) begin
			if (it.particle_index < N_PART) begin
				chain_pos[it.particle_index]  = longint'(it.position_in);
				chain_vel[it.particle_index]  = longint'(it.velocity_in);
				chain_invm[it.particle_index] = longint'({32'd0, it.inverse_mass});
			end
			acc_stale = 1'b1;
			return;
		end
		if (acc_stale) begin
			refresh_accel();
			acc_stale = 1'b0;
		end
		half_kick();
		for (int i = 0; i < N_PART; i++)
			chain_pos[i] = clamp32(chain_pos[i] + ((chain_vel[i]*dt_r) >>> 32));
		refresh_accel();
		half_kick();
		for (int i = 0; i < N_PART; i++) begin
			r.particle_out = i[5:0];
			r.position_out = zero_report ? 32'sd0 : chain_pos[i][31:0];
			r.velocity_out = zero_report ? 32'sd0 : chain_vel[i][31:0];
			r.last         = (i == N_PART-1);
			chain_report_q.push_back(r);
		end
	endtask

	// Check every report against the oldest expectation.
	always @(posedge clk) begin
		scv_pkg::scv_out_t want;
		if (valid) begin
			if (chain_report_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected report: %p", out_data);
			end else begin
				want = chain_report_q.pop_front();
				if (out_data !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("report mismatch: expected %p actual %p", want, out_data);
				end
			end
		end
	end

	function automatic scv_pkg::scv_in_t make_item(bit op, int idx, int pos, int vel,
		int invm);
		scv_pkg::scv_in_t it;
		it.op             = op;
		it.particle_index = idx[5:0];
		it.position_in    = pos;
		it.velocity_in    = vel;
		it.inverse_mass   = invm;
		return it;
	endfunction

	// Present one transaction; hold start while busy, then advance or take a gap.
	task automatic send_item(scv_pkg::scv_in_t it, bit zero_report);
		in_data = it;
		start   = 1'b1;
		do @(posedge clk); while (busy);
		advance_chain(it, zero_report);
		@(negedge clk);
		if (burst_left == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			burst_left = $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	// Drain everything, then let a load that may still be in flight settle.
	task automatic wait_idle();
		start = 1'b0;
		do @(negedge clk); while (chain_report_q.size() != 0 || busy);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(bit idx, logic [31:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == scv_pkg::REG_KAPPA) kappa_r = longint'({32'd0, val});
		else dt_r = longint'({32'd0, val});
	endtask

	function automatic int rand_q(int wide);
		if (wide) return int'($urandom());
		return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
	endfunction

	initial begin
		scv_pkg::scv_in_t stim_rows [$];
		bit      zero_rows [$];
		scv_pkg::scv_in_t it;
		int      pick;

		kappa_r = longint'(scv_pkg::KAPPA_RST);
		dt_r    = longint'(scv_pkg::DT_RST);
		acc_stale = 1'b1;
		for (int i = 0; i < N_PART; i++) begin
			chain_pos[i] = 0; chain_vel[i] = 0; chain_acc[i] = 0; chain_invm[i] = 0;
		end
		mismatch_cnt = 0;
		burst_left   = 3;

		// Directed table: a step straight out of reset reports all zero; the
		// rest hit extreme fields, zero inverse mass and out-of-range loads.
		stim_rows.push_back(make_item(scv_pkg::OP_STEP, 0, 0, 0, 0));
		zero_rows.push_back(1);
		stim_rows.push_back(make_item(scv_pkg::OP_STEP, 63, -1, -1, -1));
		zero_rows.push_back(1);
		stim_rows.push_back(make_item(scv_pkg::OP_LOAD, 0, 32'h7fffffff, 32'h80000000,
			32'hffffffff));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_LOAD, 7, 32'h80000000, 32'h7fffffff, 0));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_STEP, 0, 0, 0, 0));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_LOAD, 63, -1, -1, -1));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_STEP, 0, 0, 0, 0));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_LOAD, 8, 5, 5, 5));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_LOAD, 3, 32'h01000000, 0, 32'h00010000));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_LOAD, 4, -32'sh01000000, 32'h00800000,
			32'h00020000));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_STEP, 0, 0, 0, 0));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_STEP, 0, 0, 0, 0));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_LOAD, 1, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_LOAD, 2, 32'h80000000, 32'h80000000,
			32'h80000000));
		zero_rows.push_back(0);
		stim_rows.push_back(make_item(scv_pkg::OP_STEP, 0, 0, 0, 0));
		zero_rows.push_back(0);

		// Hold reset, then release it on a falling edge.
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[k]) send_item(stim_rows[k], zero_rows[k]);

		// Random phases, each under its own spring constant and time step.
		for (int ph = 0; ph < 5; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					write_reg(scv_pkg::REG_KAPPA, 32'hffffffff);
					write_reg(scv_pkg::REG_DT, 32'hffffffff);
				end
				1: begin
					write_reg(scv_pkg::REG_KAPPA, 32'd0);
					write_reg(scv_pkg::REG_DT, 32'd0);
				end
				2: begin
					write_reg(scv_pkg::REG_KAPPA, scv_pkg::KAPPA_RST);
					write_reg(scv_pkg::REG_DT, scv_pkg::DT_RST);
				end
				default: begin
					write_reg(scv_pkg::REG_KAPPA, $urandom_range(0, 32'h0400_0000));
					write_reg(scv_pkg::REG_DT, $urandom());
				end
			endcase
			for (int n = 0; n < 68; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					it = make_item(scv_pkg::OP_STEP, 0, 0, 0, 0);
					if (pick < 5)
						it[$bits(scv_pkg::scv_in_t)-2:0] =
							{$urandom(), $urandom(), $urandom(), 6'($urandom())};
				end else begin
					it = make_item(scv_pkg::OP_LOAD,
						(pick < 93) ? $urandom_range(0, N_PART-1) : $urandom_range(0, 63),
						rand_q(pick > 85), rand_q(pick > 85),
						(pick > 85) ? int'($urandom()) : $urandom_range(0, 32'h0004_0000));
				end
				send_item(it, 1'b0);
			end
		end

		wait_idle();
		repeat (50) @(negedge clk);
		if (mismatch_cnt == 0 && chain_report_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hang guard: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

// File: files.f
rtl/core/scv_pkg.sv
rtl/core/scv_mem.sv
rtl/core/scv_alu.sv
rtl/core/spring_chain_verlet_step_top.sv
tb/sv/tb.sv
